@@ rtl/rct_pkg.sv @@
// Shared types and codes for the recent client table.
package rct_pkg;

   localparam int REQ_DATA_W = 160;
   localparam int REQ_USER_W = 3;
   localparam int RSP_DATA_W = 8;
   localparam int WINDOW_W   = 31;
   localparam int COUNT_W    = 5;

   localparam logic [1:0] OP_RECORD = 2'd0;
   localparam logic [1:0] OP_LOOKUP = 2'd1;
   localparam logic [1:0] OP_COUNT  = 2'd2;

   localparam logic FAMILY_V4 = 1'b0;

   localparam logic [WINDOW_W-1:0] WINDOW_RESET = 31'd300;

   // One stored client: lowest field in the lowest bits
   typedef struct packed {
      logic [31:0] last_seen;
      logic [63:0] addr_lo;
      logic [63:0] addr_hi;
      logic        family;
   } entry_type;

   typedef struct packed {
      logic start;   // item taken: latch it and clear the scan
      logic scan;    // walk the table
      logic commit;  // write back and settle the result
      logic load;    // move the result into the output register
   } cmd_type;

   typedef struct packed {
      logic scan_done;
      logic rsp_free;
   } status_type;

endpackage

@@ rtl/rct_ram.sv @@
// Generic single-port-write, registered-read RAM.
module rct_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/rct_ctrl.sv @@
// Sequencer for the recent client table: take item, scan, commit, respond.
module rct_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  rct_pkg::status_type status,
   output rct_pkg::cmd_type    cmd
);

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_SCAN   = 2'd1;
   localparam logic [1:0] ST_COMMIT = 2'd2;
   localparam logic [1:0] ST_RESP   = 2'd3;

   logic [1:0] state_ff;
   logic [1:0] state_in;
   logic       accept;

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid & req_tready;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) state_in = ST_SCAN;
         end
         ST_SCAN: begin
            if (status.scan_done) state_in = ST_COMMIT;
         end
         ST_COMMIT: begin
            state_in = ST_RESP;
         end
         ST_RESP: begin
            if (status.rsp_free) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      cmd.start  = accept;
      cmd.scan   = (state_ff == ST_SCAN);
      cmd.commit = (state_ff == ST_COMMIT);
      cmd.load   = (state_ff == ST_RESP) & status.rsp_free;
   end

endmodule

@@ rtl/rct_datapath.sv @@
// Table storage, entry scan, oldest search, recent count and result register.
module rct_datapath #(
   parameter int CLIENT_SLOTS = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   input  rct_pkg::cmd_type                cmd,
   output rct_pkg::status_type             status,
   input  logic [rct_pkg::REQ_DATA_W-1:0]  req_tdata,
   input  logic [rct_pkg::REQ_USER_W-1:0]  req_tuser,
   input  logic                            csr_valid,
   input  logic [rct_pkg::WINDOW_W-1:0]    csr_data,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [rct_pkg::RSP_DATA_W-1:0]  rsp_tdata
);

   localparam int IDX_W   = $clog2(CLIENT_SLOTS);
   localparam int CNT_W   = $clog2(CLIENT_SLOTS + 1);
   localparam int ENTRY_W = $bits(rct_pkg::entry_type);
   localparam logic [CNT_W-1:0] SLOTS_CNT = CNT_W'(CLIENT_SLOTS);

   // item fields
   logic [1:0]  req_op;
   logic        req_family;
   logic [63:0] req_hi;
   logic [63:0] req_lo;
   logic [31:0] req_now;

   assign req_op     = req_tuser[1:0];
   assign req_family = req_tuser[2];
   assign req_hi     = req_tdata[63:0];
   assign req_lo     = req_tdata[127:64];
   assign req_now    = req_tdata[159:128];

   logic [1:0]  op_ff;
   logic        fam_ff;
   logic [63:0] hi_ff;
   logic [63:0] lo_ff;
   logic [31:0] now_ff;

   logic [rct_pkg::WINDOW_W-1:0] window_ff;
   logic [CNT_W-1:0]             entry_count_ff;
   logic [CNT_W-1:0]             entry_count_in;

   logic [CNT_W-1:0] issue_ff;
   logic             eval_valid_ff;
   logic [IDX_W-1:0] eval_idx_ff;

   logic             match_found_ff;
   logic [IDX_W-1:0] match_idx_ff;
   logic             match_recent_ff;
   logic [CNT_W-1:0] recent_cnt_ff;
   logic             min_valid_ff;
   logic [31:0]      min_seen_ff;
   logic [IDX_W-1:0] oldest_idx_ff;

   logic             res_hit_ff;
   logic [rct_pkg::COUNT_W-1:0] res_cnt_ff;
   logic             res_ev_ff;

   logic                           rsp_valid_ff;
   logic [rct_pkg::RSP_DATA_W-1:0] rsp_data_ff;

   // RAM ports
   logic               rd_en;
   logic [ENTRY_W-1:0] rd_data;
   logic               wr_en;
   logic [IDX_W-1:0]   wr_addr;
   rct_pkg::entry_type wr_entry;

   rct_pkg::entry_type ent;
   logic [32:0]        age;
   logic               ent_recent;
   logic               ent_match;
   logic               table_full;
   logic               is_record;
   logic               rec_miss;
   logic [rct_pkg::COUNT_W-1:0] cnt_sat;

   rct_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (CLIENT_SLOTS)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_entry),
      .rd_en   (rd_en),
      .rd_addr (issue_ff[IDX_W-1:0]),
      .rd_data (rd_data)
   );

   // Read one entry a cycle; evaluation follows in the cycle after the read
   assign rd_en = cmd.scan & (issue_ff < entry_count_ff);

   always_comb begin
      ent = rct_pkg::entry_type'(rd_data);
      // signed age: a stamp ahead of now gives a negative age, which is recent
      age = {1'b0, now_ff} - {1'b0, ent.last_seen};
      ent_recent = age[32] | (age[31:0] <= {1'b0, window_ff});
      ent_match  = (ent.family == fam_ff) & (ent.addr_hi == hi_ff) & (ent.addr_lo == lo_ff);
   end

   assign status.scan_done = (issue_ff == entry_count_ff) & ~eval_valid_ff;
   assign status.rsp_free  = ~rsp_valid_ff | rsp_tready;

   // latched item, IPv4 addresses stored with the unused bits cleared
   always_ff @(posedge clock) begin
      if (cmd.start) begin
         op_ff  <= req_op;
         fam_ff <= req_family;
         hi_ff  <= (req_family == rct_pkg::FAMILY_V4) ? {req_hi[63:32], 32'd0} : req_hi;
         lo_ff  <= (req_family == rct_pkg::FAMILY_V4) ? 64'd0 : req_lo;
         now_ff <= req_now;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff <= rct_pkg::WINDOW_RESET;
      end else if (csr_valid) begin
         window_ff <= csr_data;
      end
   end

   // scan control
   always_ff @(posedge clock) begin
      if (reset) begin
         issue_ff       <= '0;
         eval_valid_ff  <= 1'b0;
         match_found_ff <= 1'b0;
         min_valid_ff   <= 1'b0;
      end else begin
         eval_valid_ff <= rd_en;
         if (cmd.start) begin
            issue_ff       <= '0;
            match_found_ff <= 1'b0;
            min_valid_ff   <= 1'b0;
         end else begin
            if (rd_en) issue_ff <= issue_ff + CNT_W'(1);
            if (eval_valid_ff) begin
               if (ent_match) match_found_ff <= 1'b1;
               min_valid_ff <= 1'b1;
            end
         end
      end
   end

   // scan accumulators; the first match wins, ties on age keep the lower index
   always_ff @(posedge clock) begin
      eval_idx_ff <= issue_ff[IDX_W-1:0];
      if (cmd.start) begin
         recent_cnt_ff <= '0;
      end else if (eval_valid_ff) begin
         if (ent_recent) recent_cnt_ff <= recent_cnt_ff + CNT_W'(1);
         if (ent_match & ~match_found_ff) begin
            match_idx_ff    <= eval_idx_ff;
            match_recent_ff <= ent_recent;
         end
         if (~min_valid_ff | (ent.last_seen < min_seen_ff)) begin
            min_seen_ff   <= ent.last_seen;
            oldest_idx_ff <= eval_idx_ff;
         end
      end
   end

   // commit
   assign table_full = (entry_count_ff == SLOTS_CNT);
   assign is_record  = (op_ff == rct_pkg::OP_RECORD);
   assign rec_miss   = is_record & ~match_found_ff;
   assign cnt_sat    = (32'(recent_cnt_ff) > 32'd31) ? 5'd31 : rct_pkg::COUNT_W'(recent_cnt_ff);

   assign wr_en = cmd.commit & is_record;

   always_comb begin
      if (match_found_ff) begin
         wr_addr = match_idx_ff;
      end else if (table_full) begin
         wr_addr = oldest_idx_ff;
      end else begin
         wr_addr = entry_count_ff[IDX_W-1:0];
      end
      wr_entry.last_seen = now_ff;
      wr_entry.addr_lo   = lo_ff;
      wr_entry.addr_hi   = hi_ff;
      wr_entry.family    = fam_ff;
   end

   always_comb begin
      entry_count_in = entry_count_ff;
      if (cmd.commit & rec_miss & ~table_full) begin
         entry_count_in = entry_count_ff + CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_count_ff <= '0;
      end else begin
         entry_count_ff <= entry_count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         case (op_ff)
            rct_pkg::OP_RECORD: begin
               res_hit_ff <= match_found_ff;
               res_cnt_ff <= '0;
               res_ev_ff  <= rec_miss & table_full;
            end
            rct_pkg::OP_LOOKUP: begin
               res_hit_ff <= match_found_ff & match_recent_ff;
               res_cnt_ff <= '0;
               res_ev_ff  <= 1'b0;
            end
            rct_pkg::OP_COUNT: begin
               res_hit_ff <= 1'b0;
               res_cnt_ff <= cnt_sat;
               res_ev_ff  <= 1'b0;
            end
            default: begin
               res_hit_ff <= 1'b0;
               res_cnt_ff <= '0;
               res_ev_ff  <= 1'b0;
            end
         endcase
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         rsp_data_ff <= {1'b0, res_ev_ff, res_cnt_ff, res_hit_ff};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      entry_count_ff <= SLOTS_CNT)
      else $error("entry count beyond table size");

   a_eval_in_range: assert property (@(posedge clock) disable iff (reset)
      eval_valid_ff |-> ({1'b0, eval_idx_ff} < (IDX_W + 1)'(entry_count_ff)))
      else $error("evaluated entry never written");

   a_no_rw_overlap: assert property (@(posedge clock) disable iff (reset)
      !(wr_en && rd_en))
      else $error("table written during scan");

   a_count_changes_on_commit: assert property (@(posedge clock) disable iff (reset)
      (!$past(cmd.commit) && !$past(reset)) |-> $stable(entry_count_ff))
      else $error("entry count changed outside commit");

endmodule

@@ rtl/recent_client_table_unit.sv @@
// Top level of the recent client table.
//
//  channel  direction  handshake                  payload
//  req      in         req_tvalid / req_tready    tdata: addr_hi, addr_lo, now
//                                                 tuser: op, family
//  rsp      out        rsp_tvalid / rsp_tready    tdata: hit, recent_count, evicted
//  csr      in         csr_valid / csr_ready      recent_window (31 bits)
//
//  An item walks the stored entries through the table RAM, one read a cycle,
//  then commits and is loaded into the result register; input is ready again
//  in the cycle after that load. The single RAM read port sets the scan length.
//  Reset empties the table and loads recent_window with 300; no clearing pass.
//  A held result stalls the next item at its output load, input not ready
//  meanwhile; csr is always ready.
module recent_client_table_unit #(
   parameter int CLIENT_SLOTS = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // [63:0] addr_hi, [127:64] addr_lo, [159:128] now
   input  logic [rct_pkg::REQ_DATA_W-1:0]  req_tdata,
   // [1:0] op, [2] family
   input  logic [rct_pkg::REQ_USER_W-1:0]  req_tuser,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // [0] hit, [5:1] recent_count, [6] evicted, [7] zero
   output logic [rct_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [rct_pkg::WINDOW_W-1:0]    csr_data
);

   rct_pkg::cmd_type    cmd;
   rct_pkg::status_type status;

   assign csr_ready = 1'b1;

   rct_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   rct_datapath #(
      .CLIENT_SLOTS (CLIENT_SLOTS)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .csr_valid  (csr_valid),
      .csr_data   (csr_data),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule
